FILE: src/assert_macros.svh
// Assertion macros shared by the band detector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent true implies consequent in the same cycle.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Antecedent true implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

FILE: src/rlb_pkg.sv
// Types and constants of the row run line band detector.
`default_nettype none

package rlb_pkg;

	localparam int MAX_WIDTH   = 2048;
	localparam int MAX_HEIGHT  = 2048;
	localparam int RESET_DIM   = 1024;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 12;

	localparam logic [CFG_INDEX_W-1:0] REG_ROW_WIDTH    = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	// Derived geometry, held in registers next to the config port.
	typedef struct packed {
		logic [10:0] last_col;
		logic [10:0] last_row;
		logic [10:0] thresh;
	} cfg_t;

	typedef struct packed {
		logic [10:0] top;
		logic [10:0] bottom;
		logic [10:0] left_col;
		logic [10:0] right_col;
		logic [11:0] number;
	} band_t;

endpackage

`default_nettype wire

FILE: src/rlb_channels.sv
// Valid/ready channel interfaces for pixel items and band items.
`default_nettype none

interface rlb_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_level;

	modport source (output valid, output red_level, input ready);
	modport sink (input valid, input red_level, output ready);
endinterface

interface rlb_band_if;
	logic        valid;
	logic        ready;
	logic [10:0] band_top;
	logic [10:0] band_bottom;
	logic [10:0] band_left;
	logic [10:0] band_right;
	logic [11:0] band_number;

	modport source (
		output valid, output band_top, output band_bottom, output band_left,
		output band_right, output band_number, input ready
	);
	modport sink (
		input valid, input band_top, input band_bottom, input band_left,
		input band_right, input band_number, output ready
	);
endinterface

`default_nettype wire

FILE: src/rlb_cfg_regs.sv
// Configuration registers with clamped geometry and precomputed threshold.
`default_nettype none

module rlb_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [rlb_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [rlb_pkg::CFG_DATA_W-1:0]      cfg_data,
	output rlb_pkg::cfg_t                       cfg
);
	import rlb_pkg::*;

	// floor(v/3) == (v*2731) >> 13 for every v up to 2048
	localparam logic [11:0] THIRD_MUL   = 12'd2731;
	localparam int          THIRD_SHIFT = 13;

	logic [11:0] dim;
	logic [23:0] third_prod;
	cfg_t        cfg_q;

	// Clamp the written value to 1..2048.
	always_comb begin
		if (cfg_data == '0) begin
			dim = 12'd1;
		end else if (cfg_data > 12'(MAX_WIDTH)) begin
			dim = 12'(MAX_WIDTH);
		end else begin
			dim = cfg_data;
		end
		third_prod = dim * THIRD_MUL;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.last_col <= 11'(RESET_DIM - 1);
			cfg_q.last_row <= 11'(RESET_DIM - 1);
			cfg_q.thresh   <= 11'(RESET_DIM / 3);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_ROW_WIDTH: begin
					cfg_q.last_col <= 11'(dim - 12'd1);
					cfg_q.thresh   <= third_prod[THIRD_SHIFT +: 11];
				end
				REG_FRAME_HEIGHT: begin
					cfg_q.last_row <= 11'(dim - 12'd1);
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: src/row_run_line_band_detector_unit.sv
// Row run line band detector: top level with scan state and band tracking.
// Flow: a pixel item is registered in the input register, then processed; a band
//   item is loaded into the result register when the last pixel of the closing row advances.
// Throughput: one pixel item per cycle unless band_out stalls; the scan update is
//   a single pass of compares and muxes between the input and result registers.
// Reset: arst_n clears the scan position, runs, open band and band count, and
//   restores row_width and frame_height to 1024.
`default_nettype none
`include "assert_macros.svh"

module row_run_line_band_detector_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [rlb_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [rlb_pkg::CFG_DATA_W-1:0]  cfg_data,
	rlb_pixel_if.sink                       pixel_in,
	rlb_band_if.source                      band_out
);
	import rlb_pkg::*;

	cfg_t cfg;

	rlb_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Input register
	logic       valid_s1;
	logic [7:0] red_s1;

	// Scan and band state
	logic [10:0] col_q;
	logic [10:0] row_q;
	logic [11:0] cur_run_q;
	logic [10:0] cur_start_q;
	logic [11:0] best_run_q;
	logic [10:0] best_start_q;
	logic [10:0] best_stop_q;
	logic        band_open_q;
	logic [10:0] open_top_q;
	logic [10:0] open_bottom_q;
	logic [10:0] open_left_q;
	logic [10:0] open_right_q;
	logic [11:0] bands_found_q;

	// Result register
	logic  out_valid_q;
	band_t out_band_q;

	// Handshake: the stage moves when the result register is free or drains.
	logic can_go;
	logic adv;
	logic in_fire;

	assign can_go          = !out_valid_q || band_out.ready;
	assign adv             = valid_s1 && can_go;
	assign pixel_in.ready  = !valid_s1 || can_go;
	assign in_fire         = pixel_in.valid && pixel_in.ready;

	// Per-pixel combinational pass
	logic        dark;
	logic        eol;
	logic        frame_end;
	logic [11:0] run_a;
	logic [10:0] start_a;
	logic [11:0] best_run_a;
	logic [10:0] best_start_a;
	logic [10:0] best_stop_a;
	logic [11:0] best_run_f;
	logic [10:0] best_start_f;
	logic [10:0] best_stop_f;
	logic        qual;
	logic [10:0] nb_top;
	logic [10:0] nb_bottom;
	logic [10:0] nb_left;
	logic [10:0] nb_right;
	logic        emit;
	logic [11:0] bands_inc;
	band_t       emit_band;

	always_comb begin
		dark      = (red_s1 == 8'd0);
		eol       = (col_q >= cfg.last_col);
		frame_end = (row_q >= cfg.last_row);

		// A bright pixel ends the run in progress; it also marks the next start.
		best_run_a   = best_run_q;
		best_start_a = best_start_q;
		best_stop_a  = best_stop_q;
		if (dark) begin
			run_a   = cur_run_q + 12'd1;
			start_a = cur_start_q;
		end else begin
			if (cur_run_q > best_run_q) begin
				best_run_a   = cur_run_q;
				best_start_a = cur_start_q;
				best_stop_a  = col_q;
			end
			run_a   = '0;
			start_a = col_q;
		end

		// At the row end a run still open ends on the last column.
		best_run_f   = best_run_a;
		best_start_f = best_start_a;
		best_stop_f  = best_stop_a;
		if (run_a > best_run_a) begin
			best_run_f   = run_a;
			best_start_f = start_a;
			best_stop_f  = cfg.last_col;
		end

		qual = (best_run_f > {1'b0, cfg.thresh});

		// Merge the row run into the band, or open a fresh band.
		if (band_open_q) begin
			nb_top    = open_top_q;
			nb_left   = (best_start_f < open_left_q) ? best_start_f : open_left_q;
			nb_right  = (best_stop_f > open_right_q) ? best_stop_f : open_right_q;
		end else begin
			nb_top    = row_q;
			nb_left   = best_start_f;
			nb_right  = best_stop_f;
		end
		nb_bottom = row_q;

		// Close on a non-qualifying row, or on the frame end after merging.
		emit = eol && ((!qual && band_open_q) || (qual && frame_end));

		bands_inc = bands_found_q + 12'd1;

		emit_band.left_col  = qual ? nb_left : open_left_q;
		emit_band.right_col = qual ? nb_right : open_right_q;
		emit_band.top       = qual ? nb_top : open_top_q;
		emit_band.bottom    = qual ? nb_bottom : open_bottom_q;
		// Grow by one row each way, kept inside the frame.
		if (emit_band.top != '0) begin
			emit_band.top = emit_band.top - 11'd1;
		end
		if (emit_band.bottom < cfg.last_row) begin
			emit_band.bottom = emit_band.bottom + 11'd1;
		end
		emit_band.number = bands_inc;
	end

	// Input register: load on accept, drop when the stage advances.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			red_s1 <= pixel_in.red_level;
		end
	end

	// Scan and band state: advance once per processed pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q         <= '0;
			row_q         <= '0;
			cur_run_q     <= '0;
			cur_start_q   <= '0;
			best_run_q    <= '0;
			best_start_q  <= '0;
			best_stop_q   <= '0;
			band_open_q   <= 1'b0;
			open_top_q    <= '0;
			open_bottom_q <= '0;
			open_left_q   <= '0;
			open_right_q  <= '0;
			bands_found_q <= '0;
		end else if (adv) begin
			if (!eol) begin
				col_q        <= col_q + 11'd1;
				cur_run_q    <= run_a;
				cur_start_q  <= start_a;
				best_run_q   <= best_run_a;
				best_start_q <= best_start_a;
				best_stop_q  <= best_stop_a;
			end else begin
				col_q        <= '0;
				cur_run_q    <= '0;
				cur_start_q  <= '0;
				best_run_q   <= '0;
				best_start_q <= '0;
				best_stop_q  <= '0;
				if (qual) begin
					open_top_q    <= nb_top;
					open_bottom_q <= nb_bottom;
					open_left_q   <= nb_left;
					open_right_q  <= nb_right;
				end
				band_open_q <= qual && !frame_end;
				if (frame_end) begin
					row_q         <= '0;
					bands_found_q <= '0;
				end else begin
					row_q <= row_q + 11'd1;
					if (emit) begin
						bands_found_q <= bands_inc;
					end
				end
			end
		end
	end

	// Result register: take a band when the stage advances, hold while stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= emit;
		end else if (band_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			out_band_q <= emit_band;
		end
	end

	assign band_out.valid       = out_valid_q;
	assign band_out.band_top    = out_band_q.top;
	assign band_out.band_bottom = out_band_q.bottom;
	assign band_out.band_left   = out_band_q.left_col;
	assign band_out.band_right  = out_band_q.right_col;
	assign band_out.band_number = out_band_q.number;

	`ASSERT_NEXT(a_emit_shows, clk, arst_n, adv && emit, out_valid_q)
	`ASSERT_NEXT(a_frame_end_clears, clk, arst_n, adv && eol && frame_end,
		!band_open_q && bands_found_q == '0 && row_q == '0)
	`ASSERT_SAME(a_band_rows_ordered, clk, arst_n, out_valid_q,
		out_band_q.top <= out_band_q.bottom && out_band_q.number != '0)
	`ASSERT_SAME(a_empty_stage_ready, clk, arst_n, !valid_s1, pixel_in.ready)

endmodule

`default_nettype wire
